// ===== hw/rtl/dda_pkg.sv =====
// Shared types and constants for the DDA line rasterizer.
// No dependencies; imported by dda_ctrl, dda_datapath and the top level.
package dda_pkg;

    localparam int DDA_COORD_BITS = 9;
    localparam int DDA_FRAC_BITS  = 16;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    typedef enum logic {
        S_IDLE,
        S_DIVIDE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;      // latch endpoints, set position, start divide
        logic div_step;  // one quotient bit for both axes
        logic step;      // pixel request accepted
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic len_zero;  // endpoints on the inputs coincide
        logic div_last;  // final quotient bit this cycle
        logic out_free;  // output register can take a pixel
    } t_status;

endpackage

// ===== hw/rtl/dda_ctrl.sv =====
// Controller for the DDA rasterizer: input handshake and divide sequencing.
// Depends on dda_pkg.
module dda_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_action,
    input  dda_pkg::t_status i_status,
    output logic             o_in_stall,
    output dda_pkg::t_cmd    o_cmd
);
    import dda_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        o_cmd      = '0;
        w_accept   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = !i_status.out_free;
                w_accept   = i_in_valid && i_status.out_free;
                if (w_accept) begin
                    if (i_action == ACT_START) begin
                        o_cmd.load = 1'b1;
                        if (!i_status.len_zero) begin
                            n_state = S_DIVIDE;
                        end
                    end else begin
                        o_cmd.step = 1'b1;
                    end
                end
            end
            S_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== hw/rtl/dda_datapath.sv =====
// Datapath for the DDA rasterizer: position accumulators, two-lane
// restoring divider for the increments, pixel counter, output register.
// Depends on dda_pkg.
module dda_datapath #(
    parameter int COORD_BITS = dda_pkg::DDA_COORD_BITS,
    parameter int FRAC_BITS  = dda_pkg::DDA_FRAC_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  dda_pkg::t_cmd           i_cmd,
    output dda_pkg::t_status        o_status,
    input  logic [COORD_BITS-1:0]   i_x_start,
    input  logic [COORD_BITS-1:0]   i_y_start,
    input  logic [COORD_BITS-1:0]   i_x_end,
    input  logic [COORD_BITS-1:0]   i_y_end,
    input  logic                    i_out_stall,
    output logic                    o_out_valid,
    output logic signed [COORD_BITS:0] o_pixel_x,
    output logic signed [COORD_BITS:0] o_pixel_y,
    output logic                    o_last_pixel
);
    import dda_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int FB = FRAC_BITS;
    localparam int PW = CB + FB + 2;   // position width
    localparam int IW = FB + 2;        // increment width
    localparam int NW = CB + FB;       // dividend width = divide iterations
    localparam int KW = $clog2(NW);
    localparam logic [PW-1:0] HALF = {{(PW-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};

    // line setup from the input fields
    logic signed [CB:0] w_dx, w_dy, w_ndx, w_ndy;
    logic [CB-1:0]      w_adx, w_ady, w_len;
    logic [PW-1:0]      w_base_x, w_base_y;

    assign w_dx  = $signed({1'b0, i_x_end}) - $signed({1'b0, i_x_start});
    assign w_dy  = $signed({1'b0, i_y_end}) - $signed({1'b0, i_y_start});
    assign w_ndx = -w_dx;
    assign w_ndy = -w_dy;
    assign w_adx = w_dx[CB] ? w_ndx[CB-1:0] : w_dx[CB-1:0];
    assign w_ady = w_dy[CB] ? w_ndy[CB-1:0] : w_dy[CB-1:0];
    assign w_len = (w_adx > w_ady) ? w_adx : w_ady;
    assign w_base_x = {2'b00, i_x_start, {FB{1'b0}}};
    assign w_base_y = {2'b00, i_y_start, {FB{1'b0}}};

    // state
    logic [PW-1:0] r_pos_x, r_pos_y;
    logic [IW-1:0] r_inc_x, r_inc_y;
    logic [CB-1:0] r_pixels_left;
    logic [CB-1:0] r_len;
    logic [NW-1:0] r_num_x, r_num_y;   // dividend shifting out, quotient in
    logic [CB-1:0] r_rem_x, r_rem_y;
    logic          r_neg_x, r_neg_y;
    logic [KW-1:0] r_count;
    logic          r_out_valid;
    logic signed [CB:0] r_pixel_x, r_pixel_y;
    logic          r_last;

    // one restoring-division bit per lane
    logic [CB:0]   w_rsh_x, w_rsh_y, w_rsub_x, w_rsub_y;
    logic          w_q_x, w_q_y;
    logic [NW-1:0] w_quo_x, w_quo_y;
    logic [IW-1:0] w_mag_x, w_mag_y;

    assign w_rsh_x  = {r_rem_x, r_num_x[NW-1]};
    assign w_rsh_y  = {r_rem_y, r_num_y[NW-1]};
    assign w_rsub_x = w_rsh_x - {1'b0, r_len};
    assign w_rsub_y = w_rsh_y - {1'b0, r_len};
    assign w_q_x    = (w_rsh_x >= {1'b0, r_len});
    assign w_q_y    = (w_rsh_y >= {1'b0, r_len});
    assign w_quo_x  = {r_num_x[NW-2:0], w_q_x};
    assign w_quo_y  = {r_num_y[NW-2:0], w_q_y};
    assign w_mag_x  = w_quo_x[IW-1:0];
    assign w_mag_y  = w_quo_y[IW-1:0];

    // pixel from current position; floor is the arithmetic shift
    logic signed [CB+1:0] w_int_x, w_int_y;
    logic                 w_produce, w_out_free;

    assign w_int_x    = $signed(r_pos_x[PW-1:FB]);
    assign w_int_y    = $signed(r_pos_y[PW-1:FB]);
    assign w_produce  = i_cmd.step && (r_pixels_left != '0);
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x       <= '0;
            r_pos_y       <= '0;
            r_inc_x       <= '0;
            r_inc_y       <= '0;
            r_pixels_left <= '0;
            r_count       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_pos_x       <= w_dx[CB] ? w_base_x - HALF :
                                 (w_dx != '0) ? w_base_x + HALF : w_base_x;
                r_pos_y       <= w_dy[CB] ? w_base_y - HALF :
                                 (w_dy != '0) ? w_base_y + HALF : w_base_y;
                r_inc_x       <= '0;
                r_inc_y       <= '0;
                r_pixels_left <= w_len;
                r_count       <= '0;
            end else if (i_cmd.div_step) begin
                r_count <= r_count + 1'b1;
                if (r_count == KW'(NW - 1)) begin
                    r_inc_x <= r_neg_x ? -w_mag_x : w_mag_x;
                    r_inc_y <= r_neg_y ? -w_mag_y : w_mag_y;
                end
            end else if (w_produce) begin
                r_pos_x       <= r_pos_x + {{(PW-IW){r_inc_x[IW-1]}}, r_inc_x};
                r_pos_y       <= r_pos_y + {{(PW-IW){r_inc_y[IW-1]}}, r_inc_y};
                r_pixels_left <= r_pixels_left - 1'b1;
            end

            if (w_produce) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // divider payload and output payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_len   <= w_len;
            r_num_x <= {w_adx, {FB{1'b0}}};
            r_num_y <= {w_ady, {FB{1'b0}}};
            r_rem_x <= '0;
            r_rem_y <= '0;
            r_neg_x <= w_dx[CB];
            r_neg_y <= w_dy[CB];
        end else if (i_cmd.div_step) begin
            r_num_x <= w_quo_x;
            r_num_y <= w_quo_y;
            r_rem_x <= w_q_x ? w_rsub_x[CB-1:0] : w_rsh_x[CB-1:0];
            r_rem_y <= w_q_y ? w_rsub_y[CB-1:0] : w_rsh_y[CB-1:0];
        end
        if (w_produce) begin
            // clamp anything below -1 to -1
            r_pixel_x <= (w_int_x < $signed({(CB+2){1'b1}})) ? {(CB+1){1'b1}}
                                                             : w_int_x[CB:0];
            r_pixel_y <= (w_int_y < $signed({(CB+2){1'b1}})) ? {(CB+1){1'b1}}
                                                             : w_int_y[CB:0];
            r_last    <= (r_pixels_left == CB'(1));
        end
    end

    assign o_status.len_zero = (w_len == '0);
    assign o_status.div_last = (r_count == KW'(NW - 1));
    assign o_status.out_free = w_out_free;

    assign o_out_valid  = r_out_valid;
    assign o_pixel_x    = r_pixel_x;
    assign o_pixel_y    = r_pixel_y;
    assign o_last_pixel = r_last;

endmodule

// ===== hw/rtl/dda_line_rasterizer_core.sv =====
// DDA line rasterizer top level. Pixel requests are accepted back to back
// while the output register drains. A line start loads the endpoints, then
// runs the bit-per-cycle restoring divider for the increments while the input
// stalls; zero-length lines skip the divide. o_out_valid is registered and
// rises in the cycle after an accepted pixel request while pixels remain.
// Synchronous active-low reset clears position, increments and count.
module dda_line_rasterizer_core #(
    parameter int COORD_BITS = dda_pkg::DDA_COORD_BITS,
    parameter int FRAC_BITS  = dda_pkg::DDA_FRAC_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_action,
    input  logic [COORD_BITS-1:0]      i_x_start,
    input  logic [COORD_BITS-1:0]      i_y_start,
    input  logic [COORD_BITS-1:0]      i_x_end,
    input  logic [COORD_BITS-1:0]      i_y_end,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [COORD_BITS:0] o_pixel_x,
    output logic signed [COORD_BITS:0] o_pixel_y,
    output logic                       o_last_pixel
);
    import dda_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    dda_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .i_status   (w_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    dda_datapath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_x_start    (i_x_start),
        .i_y_start    (i_y_start),
        .i_x_end      (i_x_end),
        .i_y_end      (i_y_end),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_last_pixel (o_last_pixel)
    );

endmodule
